[hw/rtl/nmea_gga_sentence_receiver_unit_assert.svh]
// Assertion macros shared by the sentence receiver modules.
// Depends on nothing; included by the modules that check their own logic.
`ifndef NMEA_GGA_SENTENCE_RECEIVER_UNIT_ASSERT_SVH
`define NMEA_GGA_SENTENCE_RECEIVER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NGGA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ngga assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define NGGA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ngga assertion failed");

`endif

[hw/rtl/ngga_pkg.sv]
// Package for the GGA sentence receiver: constants, item types and codes.
// Used by every module of the block.
package ngga_pkg;

   localparam int MAX_FRAME_BYTES_DEF = 255;
   localparam int FIELD_SLOTS = 16;
   localparam int LAST_FIELD_INT = (FIELD_SLOTS - 1) < 15 ? (FIELD_SLOTS - 1) : 15;
   localparam int QUEUE_DEPTH = 2;
   localparam int HDR_LEN = 6;

   typedef logic [2:0] ngga_pos_type;
   typedef logic [3:0] ngga_field_type;

   localparam ngga_pos_type POS_HUNT = 3'd0;
   localparam ngga_pos_type POS_BODY = 3'd6;
   localparam ngga_pos_type POS_CR = 3'd7;

   localparam ngga_field_type LAST_FIELD = ngga_field_type'(LAST_FIELD_INT);
   localparam ngga_field_type CHECK_FIELD = 4'd15;

   localparam logic [7:0] HDR_CHARS [HDR_LEN] = '{8'h24, 8'h47, 8'h4E, 8'h47, 8'h47, 8'h41};
   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_STAR = 8'h2A;
   localparam logic [7:0] HEX_DEC_OFS = 8'h30;
   localparam logic [7:0] HEX_UPPER_OFS = 8'h37;
   localparam logic [7:0] HEX_LOWER_OFS = 8'h57;

   typedef struct packed {
      logic [HDR_LEN-1:0] hdr_hit;
      logic is_cr;
      logic is_lf;
      logic is_comma;
      logic is_star;
      logic hex_ok;
      logic [3:0] hex_value;
   } ngga_kind_type;

   typedef struct packed {
      logic [7:0] data;
      ngga_kind_type kind;
   } ngga_item_type;

endpackage

[hw/rtl/ngga_req_if.sv]
// Input channel of the sentence receiver: one received byte per transfer.
// Stand-alone interface with source and sink modports.
interface ngga_req_if;
   logic valid;
   logic ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

[hw/rtl/ngga_rsp_if.sv]
// Result channel of the sentence receiver: one result per received byte.
// Stand-alone interface with source and sink modports.
interface ngga_rsp_if;
   logic valid;
   logic ready;
   logic [7:0] echo_byte;
   logic [3:0] field_number;
   logic is_field_char;
   logic sentence_done;
   logic [7:0] sentence_length;
   logic [7:0] computed_sum;
   logic [7:0] received_sum;
   logic sum_matches;

   modport source (output valid, output echo_byte, output field_number,
                   output is_field_char, output sentence_done, output sentence_length,
                   output computed_sum, output received_sum, output sum_matches,
                   input ready);
   modport sink (input valid, input echo_byte, input field_number,
                 input is_field_char, input sentence_done, input sentence_length,
                 input computed_sum, input received_sum, input sum_matches,
                 output ready);
endinterface

[hw/rtl/ngga_front.sv]
// Front stage: takes received bytes and registers them with their character class.
// Depends on ngga_pkg and the ngga_req_if interface.
module ngga_front (
   input  logic                   clock,
   input  logic                   reset,
   ngga_req_if.sink               req_ch,
   output logic                   item_valid,
   input  logic                   item_ready,
   output ngga_pkg::ngga_item_type item
);

   logic valid_ff, valid_in;
   ngga_pkg::ngga_item_type item_ff, item_in;
   logic take;
   logic push;
   logic [7:0] c;

   assign c = req_ch.rx_byte;
   assign push = valid_ff && item_ready;
   assign req_ch.ready = !valid_ff || item_ready;
   assign take = req_ch.valid && req_ch.ready;

   always_comb begin
      item_in.data = c;
      for (int i = 0; i < ngga_pkg::HDR_LEN; i++) begin
         item_in.kind.hdr_hit[i] = (c == ngga_pkg::HDR_CHARS[i]);
      end
      item_in.kind.is_cr = (c == ngga_pkg::CHAR_CR);
      item_in.kind.is_lf = (c == ngga_pkg::CHAR_LF);
      item_in.kind.is_comma = (c == ngga_pkg::CHAR_COMMA);
      item_in.kind.is_star = (c == ngga_pkg::CHAR_STAR);
      item_in.kind.hex_ok = 1'b0;
      item_in.kind.hex_value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         item_in.kind.hex_ok = 1'b1;
         item_in.kind.hex_value = 4'(c - ngga_pkg::HEX_DEC_OFS);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         item_in.kind.hex_ok = 1'b1;
         item_in.kind.hex_value = 4'(c - ngga_pkg::HEX_UPPER_OFS);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         item_in.kind.hex_ok = 1'b1;
         item_in.kind.hex_value = 4'(c - ngga_pkg::HEX_LOWER_OFS);
      end
   end

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (push) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item = item_ff;

endmodule

[hw/rtl/ngga_fifo.sv]
// Short queue between the front and back stages of the sentence receiver.
// Depends on ngga_pkg and the assertion macro header.
`include "nmea_gga_sentence_receiver_unit_assert.svh"

module ngga_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    wr_valid,
   output logic                    wr_ready,
   input  ngga_pkg::ngga_item_type  wr_item,
   output logic                    rd_valid,
   input  logic                    rd_ready,
   output ngga_pkg::ngga_item_type  rd_item
);

   localparam int Depth = ngga_pkg::QUEUE_DEPTH;
   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   ngga_pkg::ngga_item_type entries [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic push, pop;

   assign wr_ready = (count_ff != CntW'(Depth));
   assign rd_valid = (count_ff != '0);
   assign push = wr_valid && wr_ready;
   assign pop = rd_valid && rd_ready;
   assign rd_item = entries[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries[wr_ptr_ff] <= wr_item;
      end
   end

   `NGGA_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CntW'(Depth))
   `NGGA_ASSERT_NEXT(a_count_up, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1)
   `NGGA_ASSERT_NEXT(a_count_down, clock, reset, pop && !push, count_ff == $past(count_ff) - 1'b1)

endmodule

[hw/rtl/ngga_back.sv]
// Back stage: header hunt, field split, checksum tracking and the result register.
// Depends on ngga_pkg, the ngga_rsp_if interface and the assertion macro header.
`include "nmea_gga_sentence_receiver_unit_assert.svh"

module ngga_back #(
   parameter int MAX_FRAME_BYTES = ngga_pkg::MAX_FRAME_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_valid,
   output logic                   item_ready,
   input  ngga_pkg::ngga_item_type item,
   ngga_rsp_if.source             rsp_ch
);

   localparam int CountW = $clog2(MAX_FRAME_BYTES + 1);
   localparam int WideW = (CountW > 8) ? CountW : 8;

   ngga_pkg::ngga_pos_type pos_ff, pos_in;
   logic [CountW-1:0] count_ff, count_in, count_sat;
   ngga_pkg::ngga_field_type field_ff, field_in;
   logic [7:0] xor_ff, xor_in;
   logic star_ff, star_in;
   logic [7:0] acc_ff, acc_in;
   logic [1:0] taken_ff, taken_in;
   logic [3:0] last_ff, last_in;

   logic pop;
   logic is_char, done;
   logic [3:0] digit;
   logic [WideW-1:0] count_wide;
   logic [7:0] len, csum, rsum;

   logic rsp_valid_ff, rsp_valid_in;
   logic [7:0] echo_ff;
   logic [3:0] fnum_ff;
   logic is_char_ff, done_ff, match_ff;
   logic [7:0] len_ff, csum_ff, rsum_ff;

   assign item_ready = !rsp_valid_ff || rsp_ch.ready;
   assign pop = item_valid && item_ready;
   assign count_sat = (count_ff < CountW'(MAX_FRAME_BYTES)) ? count_ff + 1'b1 : count_ff;
   assign digit = item.kind.hex_ok ? item.kind.hex_value : last_ff;

   always_comb begin
      pos_in = pos_ff;
      count_in = count_ff;
      field_in = field_ff;
      xor_in = xor_ff;
      star_in = star_ff;
      acc_in = acc_ff;
      taken_in = taken_ff;
      last_in = last_ff;
      is_char = 1'b0;
      done = 1'b0;

      if (pos_ff < ngga_pkg::POS_BODY) begin
         if (item.kind.hdr_hit[pos_ff]) begin
            if (pos_ff == ngga_pkg::POS_HUNT) begin
               field_in = '0;
               xor_in = '0;
               star_in = 1'b0;
               acc_in = '0;
               taken_in = '0;
               last_in = '0;
            end else begin
               xor_in = xor_ff ^ item.data;
            end
            count_in = count_sat;
            pos_in = pos_ff + 1'b1;
         end else begin
            field_in = '0;
            xor_in = '0;
            star_in = 1'b0;
            acc_in = '0;
            taken_in = '0;
            last_in = '0;
            if (item.kind.hdr_hit[0]) begin
               count_in = CountW'(1);
               pos_in = ngga_pkg::ngga_pos_type'(1);
            end else begin
               count_in = '0;
               pos_in = ngga_pkg::POS_HUNT;
            end
         end
      end else begin
         count_in = count_sat;
         if (item.kind.is_star) begin
            star_in = 1'b1;
         end else if (!star_ff) begin
            xor_in = xor_ff ^ item.data;
         end
         if (pos_ff == ngga_pkg::POS_BODY) begin
            if (item.kind.is_cr) begin
               pos_in = ngga_pkg::POS_CR;
            end else if (item.kind.is_comma || item.kind.is_star) begin
               if (field_ff < ngga_pkg::LAST_FIELD) begin
                  field_in = field_ff + 1'b1;
               end
            end else begin
               is_char = 1'b1;
               if (field_ff == ngga_pkg::CHECK_FIELD && taken_ff < 2'd2) begin
                  last_in = digit;
                  acc_in = {acc_ff[3:0], digit};
                  taken_in = taken_ff + 1'b1;
               end
            end
         end else begin
            if (item.kind.is_lf) begin
               done = 1'b1;
            end else if (!item.kind.is_cr) begin
               pos_in = ngga_pkg::POS_BODY;
            end
         end
      end

      count_wide = WideW'(count_in);
      len = (count_wide > WideW'(255)) ? 8'hFF : count_wide[7:0];
      csum = xor_in;
      rsum = (taken_in == 2'd2) ? acc_in : {last_in, last_in};
   end

   always_comb begin
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pos_ff <= ngga_pkg::POS_HUNT;
         count_ff <= '0;
         field_ff <= '0;
         xor_ff <= '0;
         star_ff <= 1'b0;
         acc_ff <= '0;
         taken_ff <= '0;
         last_ff <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            if (done) begin
               pos_ff <= ngga_pkg::POS_HUNT;
               count_ff <= '0;
               field_ff <= '0;
               xor_ff <= '0;
               star_ff <= 1'b0;
               acc_ff <= '0;
               taken_ff <= '0;
               last_ff <= '0;
            end else begin
               pos_ff <= pos_in;
               count_ff <= count_in;
               field_ff <= field_in;
               xor_ff <= xor_in;
               star_ff <= star_in;
               acc_ff <= acc_in;
               taken_ff <= taken_in;
               last_ff <= last_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         echo_ff <= item.data;
         fnum_ff <= field_in;
         is_char_ff <= is_char;
         done_ff <= done;
         len_ff <= done ? len : 8'd0;
         csum_ff <= done ? csum : 8'd0;
         rsum_ff <= done ? rsum : 8'd0;
         match_ff <= done && (csum == rsum);
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.echo_byte = echo_ff;
   assign rsp_ch.field_number = fnum_ff;
   assign rsp_ch.is_field_char = is_char_ff;
   assign rsp_ch.sentence_done = done_ff;
   assign rsp_ch.sentence_length = len_ff;
   assign rsp_ch.computed_sum = csum_ff;
   assign rsp_ch.received_sum = rsum_ff;
   assign rsp_ch.sum_matches = match_ff;

   `NGGA_ASSERT_SAME(a_taken_bound, clock, reset, 1'b1, taken_ff <= 2'd2)
   `NGGA_ASSERT_SAME(a_header_clean, clock, reset,
      pos_ff != ngga_pkg::POS_HUNT && pos_ff < ngga_pkg::POS_BODY,
      field_ff == '0 && !star_ff && taken_ff == '0)
   `NGGA_ASSERT_NEXT(a_done_clears, clock, reset,
      pop && pos_ff == ngga_pkg::POS_CR && item.kind.is_lf,
      pos_ff == ngga_pkg::POS_HUNT && count_ff == '0 && rsp_ch.sentence_done)

endmodule

[hw/rtl/nmea_gga_sentence_receiver_unit.sv]
// GGA sentence receiver, top level.
// Each transfer on req_ch carries one received character (rx_byte). The block
// hunts for the "$GNGGA" header, splits the body into fields at commas and the
// star, keeps the XOR checksum and decodes the two hex digits of the checksum
// field. Each input character yields exactly one result on rsp_ch, in order:
// the character echoed, its field index and whether it is field content.
// The result for the line feed that closes a sentence also carries the
// sentence length, the computed and received checksums and the match flag.
// An input transfer passes the classifying front register, the two-entry queue
// and the result register of the back stage before its result can transfer.
// Throughput is one character per cycle while rsp_ch.ready stays high, set by
// the state update in the back stage.
// If the receiver holds rsp_ch.ready low, the result register and the queue
// fill and req_ch.ready drops after at most four further transfers.
// A synchronous reset empties the pipeline and returns the parser to the
// header hunt with all per-sentence state cleared.
// Depends on ngga_pkg, ngga_req_if, ngga_rsp_if, ngga_front, ngga_fifo, ngga_back.
module nmea_gga_sentence_receiver_unit #(
   parameter int MAX_FRAME_BYTES = ngga_pkg::MAX_FRAME_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   ngga_req_if.sink   req_ch,
   ngga_rsp_if.source rsp_ch
);

   logic front_valid, front_ready;
   ngga_pkg::ngga_item_type front_item;
   logic queue_valid, queue_ready;
   ngga_pkg::ngga_item_type queue_item;

   ngga_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .item_valid (front_valid),
      .item_ready (front_ready),
      .item       (front_item)
   );

   ngga_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (front_valid),
      .wr_ready (front_ready),
      .wr_item  (front_item),
      .rd_valid (queue_valid),
      .rd_ready (queue_ready),
      .rd_item  (queue_item)
   );

   ngga_back #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (queue_valid),
      .item_ready (queue_ready),
      .item       (queue_item),
      .rsp_ch     (rsp_ch)
   );

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// Testbench for nmea_gga_sentence_receiver_unit: results are compared one by one against a
// table of directed bytes and, for random GGA sentences, a behavioral parser in this file.
// Depends on ngga_pkg, ngga_req_if, ngga_rsp_if and the receiver RTL.
module tb_top;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_ITEMS = 70;
   localparam int HOLD_OFF_CYCLES = 60;
   localparam logic [7:0] CHAR_DOLLAR = ngga_pkg::HDR_CHARS[0];

   typedef struct packed {
      logic [7:0] echo_byte;
      logic [3:0] field_no;
      logic       field_char;
      logic       done;
      logic [7:0] len;
      logic [7:0] calc_sum;
      logic [7:0] recv_sum;
      logic       sum_ok;
   } gga_result_type;

   typedef struct packed {
      logic [7:0] rx;
      logic       typed;
      logic [3:0] field_no;
      logic       field_char;
   } script_row_type;

   logic clock = 1'b0;
   logic reset;

   ngga_req_if req_ch ();
   ngga_rsp_if rsp_ch ();

   nmea_gga_sentence_receiver_unit u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Parser state, at its reset values.
   ngga_pkg::ngga_pos_type hdr_pos = '0;
   logic [7:0] frame_len = '0;
   logic [3:0] cur_field = '0;
   logic [7:0] calc_xor = '0;
   logic       star_flag = 1'b0;
   logic [7:0] hex_acc = '0;
   logic [1:0] hex_count = '0;
   logic [3:0] hex_prev = '0;

   gga_result_type pending_results [$];
   logic [7:0]  line_q [$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_cycles = 0;
   int items_sent = 0;
   int results_seen = 0;
   int sentences_closed = 0;
   int sums_agreed = 0;
   int mismatch_count = 0;
   int cycle_count = 0;

   script_row_type gga_script [21] = '{
      '{8'h00, 1'b1, 4'd0, 1'b0},
      '{8'hFF, 1'b1, 4'd0, 1'b0},
      '{CHAR_DOLLAR, 1'b1, 4'd0, 1'b0},
      '{"G", 1'b1, 4'd0, 1'b0},
      '{"X", 1'b1, 4'd0, 1'b0},
      '{CHAR_DOLLAR, 1'b1, 4'd0, 1'b0},
      '{"G", 1'b1, 4'd0, 1'b0},
      '{CHAR_DOLLAR, 1'b1, 4'd0, 1'b0},
      '{"G", 1'b1, 4'd0, 1'b0},
      '{"N", 1'b1, 4'd0, 1'b0},
      '{"G", 1'b1, 4'd0, 1'b0},
      '{"G", 1'b1, 4'd0, 1'b0},
      '{"A", 1'b1, 4'd0, 1'b0},
      '{ngga_pkg::CHAR_COMMA, 1'b1, 4'd1, 1'b0},
      '{ngga_pkg::CHAR_STAR, 1'b1, 4'd2, 1'b0},
      '{"a", 1'b1, 4'd2, 1'b1},
      '{ngga_pkg::CHAR_CR, 1'b1, 4'd2, 1'b0},
      '{"Z", 1'b1, 4'd2, 1'b0},
      '{ngga_pkg::CHAR_CR, 1'b1, 4'd2, 1'b0},
      '{ngga_pkg::CHAR_CR, 1'b1, 4'd2, 1'b0},
      '{ngga_pkg::CHAR_LF, 1'b0, 4'd0, 1'b0}
   };

   int idle_plan [4] = '{0, 75, 0, 10};
   int stall_plan [4] = '{0, 0, 75, 10};

   function automatic void restart_frame();
      cur_field = '0;
      calc_xor = '0;
      star_flag = 1'b0;
      hex_acc = '0;
      hex_count = '0;
      hex_prev = '0;
   endfunction

   function automatic void bump_length();
      if (frame_len < ngga_pkg::MAX_FRAME_BYTES_DEF) frame_len++;
   endfunction

   function automatic void take_hex(input logic [7:0] c);
      logic [7:0] v;
      v = {4'h0, hex_prev};
      if (c >= 8'h30 && c <= 8'h39) v = c - ngga_pkg::HEX_DEC_OFS;
      else if (c >= 8'h41 && c <= 8'h46) v = c - ngga_pkg::HEX_UPPER_OFS;
      else if (c >= 8'h61 && c <= 8'h66) v = c - ngga_pkg::HEX_LOWER_OFS;
      hex_prev = v[3:0];
      hex_acc = {hex_acc[3:0], hex_prev};
      hex_count++;
   endfunction

   function automatic gga_result_type advance_parser(input logic [7:0] c);
      gga_result_type r;
      r = '0;
      r.echo_byte = c;
      if (hdr_pos < ngga_pkg::HDR_LEN) begin
         if (c == ngga_pkg::HDR_CHARS[hdr_pos]) begin
            if (hdr_pos == ngga_pkg::POS_HUNT) restart_frame();
            else calc_xor ^= c;
            bump_length();
            hdr_pos++;
         end else if (c == CHAR_DOLLAR) begin
            restart_frame();
            frame_len = 8'd1;
            hdr_pos = ngga_pkg::ngga_pos_type'(1);
         end else begin
            restart_frame();
            frame_len = '0;
            hdr_pos = ngga_pkg::POS_HUNT;
         end
      end else begin
         bump_length();
         if (c == ngga_pkg::CHAR_STAR) star_flag = 1'b1;
         else if (!star_flag) calc_xor ^= c;
         if (hdr_pos == ngga_pkg::POS_BODY) begin
            if (c == ngga_pkg::CHAR_CR) begin
               hdr_pos = ngga_pkg::POS_CR;
            end else if (c == ngga_pkg::CHAR_COMMA || c == ngga_pkg::CHAR_STAR) begin
               if (cur_field < ngga_pkg::LAST_FIELD) cur_field++;
            end else begin
               r.field_char = 1'b1;
               if (cur_field == ngga_pkg::CHECK_FIELD && hex_count < 2) take_hex(c);
            end
         end else begin
            if (c == ngga_pkg::CHAR_LF) r.done = 1'b1;
            else if (c != ngga_pkg::CHAR_CR) hdr_pos = ngga_pkg::POS_BODY;
         end
      end
      r.field_no = cur_field;
      if (r.done) begin
         while (hex_count < 2) take_hex(8'h00);
         r.len = frame_len;
         r.calc_sum = calc_xor;
         r.recv_sum = hex_acc;
         r.sum_ok = (calc_xor == hex_acc);
         hdr_pos = ngga_pkg::POS_HUNT;
         frame_len = '0;
         restart_frame();
      end
      return r;
   endfunction

   function automatic string fmt_result(input gga_result_type r);
      return $sformatf("byte=%h field=%0d char=%b done=%b len=%0d calc=%h recv=%h ok=%b",
                       r.echo_byte, r.field_no, r.field_char, r.done, r.len,
                       r.calc_sum, r.recv_sum, r.sum_ok);
   endfunction

   function automatic logic [7:0] pick_field_char();
      logic [7:0] ch;
      if ($urandom_range(0, 6) == 0) ch = 8'($urandom_range(128, 255));
      else ch = 8'($urandom_range(32, 126));
      if (ch == ngga_pkg::CHAR_COMMA || ch == ngga_pkg::CHAR_STAR) ch = 8'h30;
      return ch;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
      if (n < 4'd10) return ngga_pkg::HEX_DEC_OFS + 8'(n);
      return (lower ? ngga_pkg::HEX_LOWER_OFS : ngga_pkg::HEX_UPPER_OFS) + 8'(n);
   endfunction

   task automatic build_sentence(input bit long_form);
      logic [7:0] sum;
      int shape;
      int nfields;
      int flen;
      int ndig;
      int k;
      bit lower;
      line_q.delete();
      shape = $urandom_range(0, 99);
      if (!long_form && shape < 12) begin
         repeat ($urandom_range(1, 6)) line_q.push_back(8'($urandom_range(0, 255)));
         return;
      end
      if (!long_form && shape < 20) begin
         k = $urandom_range(1, ngga_pkg::HDR_LEN - 1);
         for (int i = 0; i < k; i++) line_q.push_back(ngga_pkg::HDR_CHARS[i]);
         line_q.push_back($urandom_range(0, 1) ? CHAR_DOLLAR : pick_field_char());
         return;
      end
      for (int i = 0; i < ngga_pkg::HDR_LEN; i++) line_q.push_back(ngga_pkg::HDR_CHARS[i]);
      nfields = (long_form || shape < 85) ? 14 : $urandom_range(0, 20);
      for (int i = 0; i < nfields; i++) begin
         line_q.push_back(ngga_pkg::CHAR_COMMA);
         flen = long_form ? 17 : $urandom_range(0, 3);
         repeat (flen) line_q.push_back(pick_field_char());
      end
      sum = '0;
      for (int i = 1; i < line_q.size(); i++) sum ^= line_q[i];
      if ($urandom_range(0, 9) != 0) line_q.push_back(ngga_pkg::CHAR_STAR);
      if ($urandom_range(0, 4) == 0) sum ^= 8'($urandom_range(1, 255));
      ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : 2;
      lower = 1'($urandom_range(0, 1));
      if (ndig >= 1) line_q.push_back(hex_char(sum[7:4], lower));
      if (ndig == 2) begin
         if ($urandom_range(0, 9) == 0) line_q.push_back(pick_field_char());
         else line_q.push_back(hex_char(sum[3:0], lower));
      end
      line_q.push_back(ngga_pkg::CHAR_CR);
      if ($urandom_range(0, 9) == 0) begin
         line_q.push_back(pick_field_char());
         line_q.push_back(ngga_pkg::CHAR_CR);
      end
      if ($urandom_range(0, 9) == 0) line_q.push_back(ngga_pkg::CHAR_CR);
      line_q.push_back(ngga_pkg::CHAR_LF);
   endtask

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_byte(input logic [7:0] b, input bit typed, input gga_result_type want);
      gga_result_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.rx_byte <= b;
      do @(posedge clock); while (!req_ch.ready);
      predicted = advance_parser(b);
      pending_results.push_back(typed ? want : predicted);
      items_sent++;
      @(negedge clock);
   endtask

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin : result_check
      gga_result_type got;
      gga_result_type want;
      string diff;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{rsp_ch.echo_byte, rsp_ch.field_number, rsp_ch.is_field_char,
                 rsp_ch.sentence_done, rsp_ch.sentence_length, rsp_ch.computed_sum,
                 rsp_ch.received_sum, rsp_ch.sum_matches};
         results_seen++;
         if (got.done === 1'b1) sentences_closed++;
         if (got.done === 1'b1 && got.sum_ok === 1'b1) sums_agreed++;
         if (pending_results.size() == 0) begin
            if (mismatch_count < 10) $display("Unexpected result: %s", fmt_result(got));
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            diff = "";
            if (got.echo_byte !== want.echo_byte) diff = {diff, " echo_byte"};
            if (got.field_no !== want.field_no) diff = {diff, " field_number"};
            if (got.field_char !== want.field_char) diff = {diff, " is_field_char"};
            if (got.done !== want.done) diff = {diff, " sentence_done"};
            if (got.len !== want.len) diff = {diff, " sentence_length"};
            if (got.calc_sum !== want.calc_sum) diff = {diff, " computed_sum"};
            if (got.recv_sum !== want.recv_sum) diff = {diff, " received_sum"};
            if (got.sum_ok !== want.sum_ok) diff = {diff, " sum_matches"};
            if (diff != "") begin
               if (mismatch_count < 10) begin
                  $display("Result %0d differs in%s", results_seen, diff);
                  $display("  expected %s", fmt_result(want));
                  $display("  actual   %s", fmt_result(got));
               end
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding",
                  cycle_count, pending_results.size());
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      gga_result_type want;
      int phase_end;
      bit first_sentence;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.rx_byte = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (gga_script[i]) begin
         want = '0;
         want.echo_byte = gga_script[i].rx;
         want.field_no = gga_script[i].field_no;
         want.field_char = gga_script[i].field_char;
         send_byte(gga_script[i].rx, gga_script[i].typed, want);
      end

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = idle_plan[phase];
         recv_stall_pct = stall_plan[phase];
         // The receiver holds off while the sender keeps offering, so the
         // pipeline fills and input transfers stall.
         if (phase == 0) hold_cycles = HOLD_OFF_CYCLES;
         phase_end = items_sent + PHASE_ITEMS;
         first_sentence = 1'b1;
         while (items_sent < phase_end) begin
            build_sentence(phase == 0 && first_sentence);
            first_sentence = 1'b0;
            foreach (line_q[i]) send_byte(line_q[i], 1'b0, '0);
         end
      end
      req_ch.valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d bytes under four idle and stall mixes plus a long receiver hold-off.",
               items_sent);
      $display("Checked %0d results: %0d sentences closed, %0d with agreeing checksums.",
               results_seen, sentences_closed, sums_agreed);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("Some tests failed");
      end
      $finish;
   end
endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/ngga_pkg.sv
hw/rtl/ngga_req_if.sv
hw/rtl/ngga_rsp_if.sv
hw/rtl/ngga_front.sv
hw/rtl/ngga_fifo.sv
hw/rtl/ngga_back.sv
hw/rtl/nmea_gga_sentence_receiver_unit.sv
verif/tb_top.sv
